@@ rtl/stepper_divider_positioner_defines.svh @@
// assertion macros shared by the stepper positioner rtl
`ifndef STEPPER_DIVIDER_POSITIONER_DEFINES_SVH
`define STEPPER_DIVIDER_POSITIONER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SDP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SDP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sdp_pkg.sv @@
// types and constants shared by the stepper positioner modules
package sdp_pkg;

  // register map, by word index
  localparam logic REG_PULSE_INTERVAL = 1'b0;
  localparam logic REG_MOVE_STEPS     = 1'b1;

  localparam logic [7:0]  PULSE_INTERVAL_RESET = 8'd40;
  localparam logic [15:0] MOVE_STEPS_RESET     = 16'd200;

  // control flags of the motor state
  typedef struct packed {
    logic pulse_ready;
    logic motion_enable;
    logic target_side;
    logic last_target;
    logic complete_flag;
    logic homed_flag;
    logic homing_started;
    logic dir_level;
    logic enable_level;
  } flags_t;

  // one result beat
  typedef struct packed {
    logic        step_pulse;
    logic        direction;
    logic        driver_enable;
    logic        homed;
    logic        move_done;
    logic [15:0] steps_taken;
  } result_t;

endpackage

@@ rtl/sdp_ctrl.sv @@
// pulse generator and homing / positioning state, one tick per accepted beat
`include "stepper_divider_positioner_defines.svh"

module sdp_ctrl #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              pulse_tick,
  input  logic              task_tick,
  input  logic              home_switch,
  input  logic              ball_left,
  input  logic              ball_right,
  input  logic [7:0]        pulse_interval,
  input  logic [15:0]       move_steps,
  output sdp_pkg::result_t  res
);

  sdp_pkg::flags_t         flags;
  sdp_pkg::flags_t         flags_next;
  logic [7:0]              tick_counter;
  logic [7:0]              tick_counter_next;
  logic [COUNT_BITS-1:0]   step_count;
  logic [COUNT_BITS-1:0]   step_count_next;
  logic [COUNT_BITS+15:0]  count_ext;

  // next state for one tick
  always_comb begin
    flags_next        = flags;
    tick_counter_next = tick_counter;
    step_count_next   = step_count;

    // pulse generator
    if (pulse_tick) begin
      tick_counter_next = tick_counter + 8'd1;
      if (!flags.pulse_ready) begin
        flags_next.pulse_ready = 1'b1;
      end else if (flags.motion_enable && (tick_counter_next >= pulse_interval)) begin
        tick_counter_next      = 8'd0;
        step_count_next        = step_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        flags_next.pulse_ready = 1'b0;
      end
    end

    // control step
    if (task_tick) begin
      if (ball_left) begin
        flags_next.target_side = 1'b1;
      end
      if (ball_right) begin
        flags_next.target_side = 1'b0;
      end
      if (!flags.homed_flag) begin
        // homing: drive toward the home switch
        if (!flags_next.homing_started) begin
          flags_next.homing_started = 1'b1;
          flags_next.enable_level   = 1'b1;
          flags_next.dir_level      = 1'b1;
          flags_next.motion_enable  = 1'b1;
        end
        if (home_switch) begin
          flags_next.enable_level   = 1'b0;
          flags_next.dir_level      = 1'b0;
          flags_next.motion_enable  = 1'b0;
          step_count_next           = '0;
          flags_next.homing_started = 1'b0;
          flags_next.homed_flag     = 1'b1;
        end
      end else begin
        // positioning: start a move on a new target and stop it when the move completes
        if (flags_next.last_target != flags_next.target_side) begin
          flags_next.dir_level     = !flags_next.target_side;
          flags_next.complete_flag = 1'b0;
          step_count_next          = '0;
          flags_next.enable_level  = 1'b1;
          flags_next.motion_enable = 1'b1;
        end
        flags_next.last_target = flags_next.target_side;
        if (!flags_next.complete_flag) begin
          if (flags_next.target_side) begin
            if ({16'b0, step_count_next} >= {{COUNT_BITS{1'b0}}, move_steps}) begin
              flags_next.complete_flag = 1'b1;
            end
          end else if (home_switch) begin
            flags_next.complete_flag = 1'b1;
          end
          if (flags_next.complete_flag) begin
            flags_next.enable_level  = 1'b0;
            flags_next.motion_enable = 1'b0;
            step_count_next          = '0;
          end
        end
      end
    end
  end

  // result from the state after this tick
  assign count_ext = {16'b0, step_count_next};

  always_comb begin
    res.step_pulse    = !flags_next.pulse_ready;
    res.direction     = flags_next.dir_level;
    res.driver_enable = flags_next.enable_level;
    res.homed         = flags_next.homed_flag;
    res.move_done     = flags_next.complete_flag;
    res.steps_taken   = count_ext[15:0];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= '{pulse_ready: 1'b1, default: 1'b0};
      tick_counter <= 8'd0;
      step_count   <= '0;
    end else if (en) begin
      flags        <= flags_next;
      tick_counter <= tick_counter_next;
      step_count   <= step_count_next;
    end
  end

  `SDP_ASSERT_NEXT(a_pulse_one_tick, en && pulse_tick && !flags.pulse_ready,
    flags.pulse_ready, "step pulse lasted more than one tick")
  `SDP_ASSERT_IMPL(a_done_stops_motor, flags.complete_flag,
    !flags.motion_enable && !flags.enable_level, "completed move still driving the motor")
  `SDP_ASSERT_NEXT(a_homed_sticks, flags.homed_flag, flags.homed_flag,
    "homed flag dropped")

endmodule

@@ rtl/stepper_divider_positioner.sv @@
// stepper positioner top level: apb registers, control state and result buffer
// the result of each accepted tick beat is registered into the result buffer
// throughput: one tick beat per cycle while the result buffer is not full
// a two-entry result buffer keeps input beats flowing while one result waits
// reset: synchronous active-high rst clears the motor state, empties the result buffer
// and loads pulse_interval 40 and move_steps 200
`include "stepper_divider_positioner_defines.svh"

module stepper_divider_positioner #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // tick channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pulse_tick,
  input  logic        task_tick,
  input  logic        home_switch,
  input  logic        ball_left,
  input  logic        ball_right,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        step_pulse,
  output logic        direction,
  output logic        driver_enable,
  output logic        homed,
  output logic        move_done,
  output logic [15:0] steps_taken,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]        pulse_interval;
  logic [15:0]       move_steps;
  logic              cfg_wr;
  logic              push;
  logic              pop;
  logic [1:0]        count;
  sdp_pkg::result_t  res;
  sdp_pkg::result_t  slot0;
  sdp_pkg::result_t  slot1;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_interval <= sdp_pkg::PULSE_INTERVAL_RESET;
      move_steps     <= sdp_pkg::MOVE_STEPS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        sdp_pkg::REG_PULSE_INTERVAL: pulse_interval <= pwdata[7:0];
        sdp_pkg::REG_MOVE_STEPS:     move_steps     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      sdp_pkg::REG_PULSE_INTERVAL: prdata = {24'b0, pulse_interval};
      sdp_pkg::REG_MOVE_STEPS:     prdata = {16'b0, move_steps};
      default:                     prdata = 32'b0;
    endcase
  end

  // tick handshake
  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;

  sdp_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .en             (push),
    .pulse_tick     (pulse_tick),
    .task_tick      (task_tick),
    .home_switch    (home_switch),
    .ball_left      (ball_left),
    .ball_right     (ball_right),
    .pulse_interval (pulse_interval),
    .move_steps     (move_steps),
    .res            (res)
  );

  // result buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // result buffer payload, slot0 is the head
  always_ff @(posedge clk) begin
    if (push && pop) begin
      slot0 <= res;
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

  assign step_pulse    = slot0.step_pulse;
  assign direction     = slot0.direction;
  assign driver_enable = slot0.driver_enable;
  assign homed         = slot0.homed;
  assign move_done     = slot0.move_done;
  assign steps_taken   = slot0.steps_taken;

  `SDP_ASSERT_IMPL(a_no_overflow, push, count != 2'd2, "tick beat taken with result buffer full")
  `SDP_ASSERT_NEXT(a_pop_drains, pop && !push, count == $past(count) - 2'd1, "result beat taken without draining")
  `SDP_ASSERT_NEXT(a_push_fills, push && !pop, count == $past(count) + 2'd1, "tick beat accepted without filling buffer")

endmodule
